>>> rtl/core/wma_pkg.sv
`default_nettype none
package wma_pkg;

    // channel geometry
    localparam int CH_SLOTS     = 9;
    localparam int NUM_CHANNELS = 9;
    localparam int MAX_SAMPLES  = 65535;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 40;
    localparam int COUNT_W  = 16;
    localparam int TIME_W   = 32;
    localparam int ENTRY_W  = 8;
    localparam int ACTION_W = 2;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // divider geometry: quotient bits, remainder and dividend widths
    localparam int QUO_W  = 24;
    localparam int DIVD_W = SUM_W + 1;
    localparam int DIVS_W = COUNT_W + 1;
    localparam int ITER_W = $clog2(QUO_W);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'd1;

    localparam logic [TIME_W-1:0]  INTERVAL_RST    = 32'd300000;
    localparam logic [ENTRY_W-1:0] MAX_ENTRIES_RST = 8'd96;

    // per-lane operation strobes from the sequencer
    typedef struct packed {
        logic add;
        logic absorb;
        logic bias;
        logic step;
        logic fix;
    } lane_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/wma_if.sv
`default_nettype none
interface wma_in_if;
    import wma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] probe_temp;
    logic signed [SAMPLE_W-1:0] air_temp;
    logic signed [SAMPLE_W-1:0] aux_temp;
    logic signed [SAMPLE_W-1:0] humidity;
    logic signed [SAMPLE_W-1:0] light;
    logic signed [SAMPLE_W-1:0] co2;
    logic signed [SAMPLE_W-1:0] voc;
    logic signed [SAMPLE_W-1:0] aqi;
    logic signed [SAMPLE_W-1:0] pressure;
    logic [TIME_W-1:0]          unix_time;
    logic [TIME_W-1:0]          now_ms;

    modport source (
        output valid, action, probe_temp, air_temp, aux_temp, humidity, light,
               co2, voc, aqi, pressure, unix_time, now_ms,
        input  ready
    );
    modport sink (
        input  valid, action, probe_temp, air_temp, aux_temp, humidity, light,
               co2, voc, aqi, pressure, unix_time, now_ms,
        output ready
    );
endinterface

interface wma_out_if;
    import wma_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [TIME_W-1:0]          window_time;
    logic signed [SAMPLE_W-1:0] avg_probe_temp;
    logic signed [SAMPLE_W-1:0] avg_air_temp;
    logic signed [SAMPLE_W-1:0] avg_aux_temp;
    logic signed [SAMPLE_W-1:0] avg_humidity;
    logic signed [SAMPLE_W-1:0] avg_light;
    logic signed [SAMPLE_W-1:0] avg_co2;
    logic signed [SAMPLE_W-1:0] avg_voc;
    logic signed [SAMPLE_W-1:0] avg_aqi;
    logic signed [SAMPLE_W-1:0] avg_pressure;
    logic [COUNT_W-1:0]         sample_count;
    logic                       dropped;

    modport source (
        output valid, window_time, avg_probe_temp, avg_air_temp, avg_aux_temp,
               avg_humidity, avg_light, avg_co2, avg_voc, avg_aqi, avg_pressure,
               sample_count, dropped,
        input  ready
    );
    modport sink (
        input  valid, window_time, avg_probe_temp, avg_air_temp, avg_aux_temp,
               avg_humidity, avg_light, avg_co2, avg_voc, avg_aqi, avg_pressure,
               sample_count, dropped,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/core/windowed_multichannel_average.sv
// Boxcar window averager over nine signed sensor channels.
// samples (valid/ready sink): one item per reading set; action selects sample,
// flush or store-cleared. results (valid/ready source): one item per closed
// window with start time, nine rounded averages, count and a dropped flag.
// cfg_we/cfg_index/cfg_data write interval_ms (0) and max_entries (1).
// A sample that does not close its window leaves the block idle. An item that
// closes a window occupies the block while the sequencer runs: ABS takes the
// sums, BIAS forms the rounded dividend, DIV runs the bit-per-cycle divider in
// each of the nine lanes, FIX restores the sign and HOLD loads the output
// register; the result is valid on the next cycle. A dropped window skips the
// divider and goes from ABS straight to HOLD. samples.ready is low while a window is closing.
// The output register holds a result until taken; samples keep being taken
// meanwhile, and only a following close waits for the register to empty.
// Reset clears the sums, counts, store fill and restores interval_ms to 300000
// and max_entries to 96; no result is pending after reset.
`default_nettype none
module windowed_multichannel_average (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    wma_in_if.sink                             samples,
    wma_out_if.source                          results,
    input  wire logic                          cfg_we,
    input  wire logic [wma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wma_pkg::CFG_W-1:0]     cfg_data
);
    import wma_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ABS  = 3'd1;
    localparam logic [2:0] ST_BIAS = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIX  = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [TIME_W-1:0]   interval_reg;
    logic [ENTRY_W-1:0]  max_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0]   start_ms_reg, start_ms_next;
    logic [TIME_W-1:0]   start_time_reg, start_time_next;
    logic [ENTRY_W-1:0]  stored_reg, stored_next;
    logic [TIME_W-1:0]   res_time_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                drop_reg;

    logic                accept, is_sample, is_flush, is_clear, first;
    logic [TIME_W-1:0]   elapsed;
    logic [COUNT_W-1:0]  count_inc;
    logic                close, full, merge_free, merge_load;
    lane_cmd_t           cmd;

    logic signed [SAMPLE_W-1:0] chan_in  [CH_SLOTS];
    logic signed [SAMPLE_W-1:0] lane_avg [CH_SLOTS];

    assign samples.ready = state_reg == ST_IDLE;
    assign accept    = samples.valid && samples.ready;
    assign is_sample = samples.action == ACT_SAMPLE;
    assign is_flush  = samples.action == ACT_FLUSH;
    assign is_clear  = samples.action == ACT_CLEAR;
    assign first     = count_reg == '0;
    assign count_inc = count_reg + COUNT_W'(1);
    assign elapsed   = first ? '0 : samples.now_ms - start_ms_reg;
    assign full      = stored_reg >= max_reg;
    assign close     = accept && ((is_sample && (elapsed >= interval_reg ||
                                  count_inc == COUNT_W'(MAX_SAMPLES)))
                               || (is_flush && !first));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RST;
            max_reg      <= MAX_ENTRIES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERVAL:    interval_reg <= cfg_data;
                REG_MAX_ENTRIES: max_reg      <= cfg_data[ENTRY_W-1:0];
                default:         ;
            endcase
        end
    end

    // window bookkeeping on each accepted item
    always_comb
    begin
        count_next      = count_reg;
        start_ms_next   = start_ms_reg;
        start_time_next = start_time_reg;
        stored_next     = stored_reg;
        if (accept)
        begin
            if (is_sample)
            begin
                count_next = count_inc;
                if (first)
                begin
                    start_ms_next   = samples.now_ms;
                    start_time_next = samples.unix_time;
                end
            end
            if (is_clear)
            begin
                stored_next = '0;
            end
            if (close)
            begin
                count_next    = '0;
                start_ms_next = samples.now_ms;
                if (!full)
                begin
                    stored_next = stored_reg + ENTRY_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            start_ms_reg   <= '0;
            start_time_reg <= '0;
            stored_reg     <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            start_ms_reg   <= start_ms_next;
            start_time_reg <= start_time_next;
            stored_reg     <= stored_next;
        end
    end

    // latch what the closed window reports
    always_ff @(posedge clk)
    begin
        if (close)
        begin
            res_time_reg  <= (is_sample && first) ? samples.unix_time : start_time_reg;
            res_count_reg <= is_sample ? count_inc : count_reg;
            drop_reg      <= full;
        end
    end

    // close sequencer
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        merge_load = 1'b0;
        cmd        = '0;
        cmd.add    = accept && is_sample;
        case (state_reg)
            ST_IDLE:
            begin
                if (close)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                cmd.absorb = 1'b1;
                state_next = drop_reg ? ST_HOLD : ST_BIAS;
            end
            ST_BIAS:
            begin
                cmd.bias   = 1'b1;
                iter_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(QUO_W - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (merge_free)
                begin
                    merge_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    assign chan_in[0] = samples.probe_temp;
    assign chan_in[1] = samples.air_temp;
    assign chan_in[2] = samples.aux_temp;
    assign chan_in[3] = samples.humidity;
    assign chan_in[4] = samples.light;
    assign chan_in[5] = samples.co2;
    assign chan_in[6] = samples.voc;
    assign chan_in[7] = samples.aqi;
    assign chan_in[8] = samples.pressure;

    // one accumulator and divider per active channel
    for (genvar g = 0; g < CH_SLOTS; g++)
    begin : g_lane
        if (g < NUM_CHANNELS)
        begin : g_on
            wma_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (cmd),
                .sample (chan_in[g]),
                .count  (res_count_reg),
                .avg    (lane_avg[g])
            );
        end
        else
        begin : g_off
            assign lane_avg[g] = '0;
        end
    end

    wma_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (merge_load),
        .dropped      (drop_reg),
        .window_time  (res_time_reg),
        .sample_count (res_count_reg),
        .lane_avg     (lane_avg),
        .free         (merge_free),
        .results      (results)
    );

`ifndef SYNTHESIS
    // an idle block never sits on a full window
    a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> count_reg != COUNT_W'(MAX_SAMPLES))
        else $error("window count reached limit without closing");

    // divider step counter stays within the quotient width
    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> iter_reg <= ITER_W'(QUO_W - 1))
        else $error("divider step count out of range");

    // a loaded result shows up on the output next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        merge_load |=> results.valid && results.sample_count == $past(res_count_reg))
        else $error("closed window not presented");

    // a dropped window reports no averages
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.dropped |->
            results.avg_probe_temp == '0 && results.avg_pressure == '0)
        else $error("dropped window carries averages");
`endif

endmodule
`default_nettype wire

>>> rtl/core/wma_lane.sv
`default_nettype none
module wma_lane (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire wma_pkg::lane_cmd_t                  cmd,
    input  wire logic signed [wma_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [wma_pkg::COUNT_W-1:0]         count,
    output logic signed [wma_pkg::SAMPLE_W-1:0]      avg
);
    import wma_pkg::*;

    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]         mag_reg;
    logic                     neg_reg;
    logic [DIVS_W-1:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic [DIVD_W-1:0]        dividend;
    logic [DIVS_W-1:0]        divisor;
    logic [DIVS_W:0]          trial;
    logic                     fits;

    // accumulate samples, clear when the window is taken for division
    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.add)
        begin
            sum_next = sum_reg + SUM_W'(sample);
        end
        else if (cmd.absorb)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // rounded quotient: (2*|sum| + n) / (2*n), one bit per step
    assign divisor  = {count, 1'b0};
    assign dividend = {mag_reg, 1'b0} + DIVD_W'(count);
    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign fits     = trial >= (DIVS_W + 1)'(divisor);

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.bias)
        begin
            rem_next = dividend[DIVD_W-1:QUO_W];
            quo_next = dividend[QUO_W-1:0];
        end
        else if (cmd.step)
        begin
            rem_next = fits ? DIVS_W'(trial - (DIVS_W + 1)'(divisor))
                            : trial[DIVS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        // restore the sign, ties already rounded away from zero
        if (cmd.fix)
        begin
            avg_reg <= neg_reg ? SAMPLE_W'(-quo_reg) : SAMPLE_W'(quo_reg);
        end
    end

    assign avg = avg_reg;

endmodule
`default_nettype wire

>>> rtl/core/wma_merge.sv
`default_nettype none
module wma_merge (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire logic                                dropped,
    input  wire logic [wma_pkg::TIME_W-1:0]          window_time,
    input  wire logic [wma_pkg::COUNT_W-1:0]         sample_count,
    input  wire logic signed [wma_pkg::SAMPLE_W-1:0] lane_avg [wma_pkg::CH_SLOTS],
    output logic                                     free,
    wma_out_if.source                                results
);
    import wma_pkg::*;

    logic                       valid_reg, valid_next;
    logic [TIME_W-1:0]          time_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic                       drop_reg;
    logic signed [SAMPLE_W-1:0] avg_reg [CH_SLOTS];

    assign free = !valid_reg || results.ready;

    // hold a result until taken, take a new one when free
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // gather the lanes; a dropped window reports zero averages
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            time_reg  <= window_time;
            count_reg <= sample_count;
            drop_reg  <= dropped;
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                avg_reg[i] <= dropped ? '0 : lane_avg[i];
            end
        end
    end

    assign results.valid          = valid_reg;
    assign results.window_time    = time_reg;
    assign results.sample_count   = count_reg;
    assign results.dropped        = drop_reg;
    assign results.avg_probe_temp = avg_reg[0];
    assign results.avg_air_temp   = avg_reg[1];
    assign results.avg_aux_temp   = avg_reg[2];
    assign results.avg_humidity   = avg_reg[3];
    assign results.avg_light      = avg_reg[4];
    assign results.avg_co2        = avg_reg[5];
    assign results.avg_voc        = avg_reg[6];
    assign results.avg_aqi        = avg_reg[7];
    assign results.avg_pressure   = avg_reg[8];

endmodule
`default_nettype wire

>>> sim/tb_windowed_multichannel_average.sv
`default_nettype none
module tb_windowed_multichannel_average;
    timeunit 1ns;
    timeprecision 1ps;

    import wma_pkg::*;

    localparam int CLK_HALF_NS   = 2;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_LOGGED    = 40;
    localparam int PHASE_ITEMS   = 160;
    localparam int NUM_PHASES    = 8;
    localparam int LONG_WINDOW   = 200;

    // the one action code the block must ignore
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]                   action;
        logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] reading;
        logic [TIME_W-1:0]                     unix_time;
        logic [TIME_W-1:0]                     now_ms;
    } reading_set_t;

    typedef struct packed {
        logic [TIME_W-1:0]                     window_time;
        logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] avg;
        logic [COUNT_W-1:0]                    sample_count;
        logic                                  dropped;
    } window_t;

    string lane_name [NUM_CHANNELS] = '{"probe_temp", "air_temp", "aux_temp", "humidity",
                                        "light", "co2", "voc", "aqi", "pressure"};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    wma_in_if  samples_if ();
    wma_out_if results_if ();

    windowed_multichannel_average u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // free running clock
    always
    begin
        #(CLK_HALF_NS) clk = 1'b1;
        #(CLK_HALF_NS) clk = 1'b0;
    end

    // predicted block state and configuration
    longint            lane_sum [NUM_CHANNELS];
    int                win_count      = 0;
    logic [TIME_W-1:0] win_start_ms   = '0;
    logic [TIME_W-1:0] win_start_unix = '0;
    logic [ENTRY_W-1:0] windows_stored = '0;
    logic [TIME_W-1:0] cfg_interval   = INTERVAL_RST;
    logic [ENTRY_W-1:0] cfg_max       = MAX_ENTRIES_RST;

    window_t pending_windows [$];

    // stimulus time base and traffic knobs
    logic [TIME_W-1:0] ms_now   = '0;
    logic [TIME_W-1:0] unix_now = '0;
    bit calm      = 1'b0;
    int sink_hold = 0;
    int sink_wait = 0;

    // bookkeeping
    int mismatches  = 0;
    int n_windows   = 0;
    int n_dropped   = 0;
    int cycle_count = 0;
    int act_seen [4] = '{0, 0, 0, 0};

    initial
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
            lane_sum[i] = 0;
    end

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_LOGGED)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // close the open window, if any, and queue the window it yields
    function automatic void emit_window(input logic [TIME_W-1:0] now);
        window_t w;
        longint  mag;
        longint  quo;
        longint  avg;
        if (win_count == 0)
            return;
        w              = '0;
        w.window_time  = win_start_unix;
        w.sample_count = COUNT_W'(win_count);
        if (windows_stored >= cfg_max)
        begin
            w.dropped = 1'b1;
        end
        else
        begin
            // round to nearest, ties away from zero
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                mag = (lane_sum[i] < 0) ? -lane_sum[i] : lane_sum[i];
                quo = (mag * 2 + longint'(win_count)) / (longint'(win_count) * 2);
                avg = (lane_sum[i] < 0) ? -quo : quo;
                w.avg[i] = avg[SAMPLE_W-1:0];
            end
            windows_stored = windows_stored + 8'd1;
        end
        pending_windows.push_back(w);
        for (int i = 0; i < NUM_CHANNELS; i++)
            lane_sum[i] = 0;
        win_count    = 0;
        win_start_ms = now;
    endfunction

    // advance the predicted state by one accepted item
    function automatic void absorb_item(input reading_set_t it);
        logic [TIME_W-1:0] elapsed;
        case (it.action)
            ACT_FLUSH:
                emit_window(it.now_ms);
            ACT_CLEAR:
                windows_stored = '0;
            ACT_SAMPLE:
            begin
                if (win_count == 0)
                begin
                    win_start_unix = it.unix_time;
                    win_start_ms   = it.now_ms;
                end
                for (int i = 0; i < NUM_CHANNELS; i++)
                    lane_sum[i] += longint'($signed(it.reading[i]));
                win_count = (win_count + 1) & 32'hFFFF;
                elapsed   = it.now_ms - win_start_ms;
                if (elapsed >= cfg_interval || win_count >= MAX_SAMPLES)
                    emit_window(it.now_ms);
            end
            default: ;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random readings, biased toward the extremes and small values
    function automatic reading_set_t rand_item(input logic [ACTION_W-1:0] act);
        reading_set_t it;
        int unsigned  r;
        it.action = act;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
                it.reading[i] = 24'h800000;
            else if (r == 1)
                it.reading[i] = 24'h7FFFFF;
            else if (r < 5)
                it.reading[i] = SAMPLE_W'($urandom_range(0, 400)) - 24'd200;
            else
                it.reading[i] = SAMPLE_W'($urandom);
        end
        it.unix_time = unix_now;
        it.now_ms    = ms_now;
        return it;
    endfunction

    // move the millisecond clock, sized to the current window length
    function automatic void tick_time();
        int unsigned       r;
        logic [TIME_W-1:0] span;
        r    = $urandom_range(0, 19);
        span = (cfg_interval > 4000) ? 32'd4000 : cfg_interval / 3 + 1;
        case (r)
            0:       ms_now += $urandom;
            1:       ms_now += cfg_interval;
            2:       ms_now += cfg_interval - 1;
            default: ms_now += $urandom_range(0, span);
        endcase
        unix_now += (r == 3) ? $urandom : $urandom_range(0, 2);
    endfunction

    // offer one item until taken, then idle for a random gap
    task automatic send_item(input reading_set_t it);
        int gap;
        samples_if.valid      <= 1'b1;
        samples_if.action     <= it.action;
        samples_if.probe_temp <= it.reading[0];
        samples_if.air_temp   <= it.reading[1];
        samples_if.aux_temp   <= it.reading[2];
        samples_if.humidity   <= it.reading[3];
        samples_if.light      <= it.reading[4];
        samples_if.co2        <= it.reading[5];
        samples_if.voc        <= it.reading[6];
        samples_if.aqi        <= it.reading[7];
        samples_if.pressure   <= it.reading[8];
        samples_if.unix_time  <= it.unix_time;
        samples_if.now_ms     <= it.now_ms;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every window is out and the block is quiet
    task automatic drain_results();
        samples_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_INTERVAL:    cfg_interval = value;
            REG_MAX_ENTRIES: cfg_max      = value[ENTRY_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // reset values: flush on empty, window closing exactly at the interval
    task automatic test_reset_defaults();
        ms_now   = 32'd1000;
        unix_now = 32'd1700000000;
        send_item(rand_item(ACT_FLUSH));
        repeat (5)
        begin
            send_item(rand_item(ACT_SAMPLE));
            ms_now   += 32'd1000;
            unix_now += 32'd1;
        end
        ms_now = 32'd1000 + INTERVAL_RST - 32'd1;
        send_item(rand_item(ACT_SAMPLE));
        ms_now += 32'd1;
        send_item(rand_item(ACT_SAMPLE));
        send_item(rand_item(ACT_SAMPLE));
        send_item(rand_item(ACT_FLUSH));
    endtask

    // full-scale readings, rounding ties, ignored action, empty flush
    task automatic test_rounding_extremes();
        reading_set_t it;
        drain_results();
        write_reg(REG_INTERVAL, 32'hFFFFFFFF);
        write_reg(REG_MAX_ENTRIES, 32'd255);
        ms_now   = 32'hFFFFFFFF;
        unix_now = 32'hFFFFFFFF;
        it         = rand_item(ACT_SAMPLE);
        it.reading = {NUM_CHANNELS{24'h7FFFFF}};
        send_item(it);
        ms_now   = '0;
        unix_now = '0;
        it         = rand_item(ACT_SAMPLE);
        it.reading = {NUM_CHANNELS{24'h800000}};
        send_item(it);
        send_item(rand_item(ACT_FLUSH));
        send_item(rand_item(ACT_FLUSH));
        send_item(rand_item(ACT_UNUSED));
        send_item(rand_item(ACT_CLEAR));
        // half-way sums: positive lanes round up, negative lanes round down
        for (int k = 1; k <= 2; k++)
        begin
            it = rand_item(ACT_SAMPLE);
            for (int i = 0; i < NUM_CHANNELS; i++)
                it.reading[i] = (i % 2 == 0) ? SAMPLE_W'(k) : -SAMPLE_W'(k);
            send_item(it);
        end
        send_item(rand_item(ACT_FLUSH));
    endtask

    // elapsed time across the millisecond wrap, zero and one ms windows
    task automatic test_window_timing();
        drain_results();
        write_reg(REG_INTERVAL, 32'h200);
        ms_now = 32'hFFFFFF00;
        send_item(rand_item(ACT_SAMPLE));
        ms_now = 32'h000000FF;
        send_item(rand_item(ACT_SAMPLE));
        ms_now = 32'h00000100;
        send_item(rand_item(ACT_SAMPLE));
        drain_results();
        write_reg(REG_INTERVAL, 32'd0);
        send_item(rand_item(ACT_SAMPLE));
        send_item(rand_item(ACT_SAMPLE));
        drain_results();
        write_reg(REG_INTERVAL, 32'd1);
        send_item(rand_item(ACT_SAMPLE));
        send_item(rand_item(ACT_SAMPLE));
        ms_now += 32'd1;
        send_item(rand_item(ACT_SAMPLE));
    endtask

    // fill the store, drop windows, clear it, then the zero and one limits
    task automatic test_store_limit();
        drain_results();
        write_reg(REG_INTERVAL, 32'd0);
        write_reg(REG_MAX_ENTRIES, 32'd2);
        send_item(rand_item(ACT_CLEAR));
        repeat (4) send_item(rand_item(ACT_SAMPLE));
        send_item(rand_item(ACT_CLEAR));
        send_item(rand_item(ACT_SAMPLE));
        drain_results();
        write_reg(REG_MAX_ENTRIES, 32'd0);
        repeat (2) send_item(rand_item(ACT_SAMPLE));
        send_item(rand_item(ACT_CLEAR));
        send_item(rand_item(ACT_SAMPLE));
        drain_results();
        write_reg(REG_MAX_ENTRIES, 32'd1);
        repeat (2) send_item(rand_item(ACT_SAMPLE));
    endtask

    // a long window of back to back samples, full-scale on the first two lanes, closed by a flush
    task automatic test_long_window();
        reading_set_t it;
        drain_results();
        write_reg(REG_INTERVAL, 32'hFFFFFFFF);
        write_reg(REG_MAX_ENTRIES, 32'd255);
        send_item(rand_item(ACT_CLEAR));
        calm = 1'b1;
        for (int k = 0; k < LONG_WINDOW; k++)
        begin
            it            = rand_item(ACT_SAMPLE);
            it.reading[0] = 24'h800000;
            it.reading[1] = 24'h7FFFFF;
            send_item(it);
        end
        calm = 1'b0;
        send_item(rand_item(ACT_SAMPLE));
        send_item(rand_item(ACT_FLUSH));
    endtask

    // stall the receiver long enough that the block stops taking items
    task automatic test_backpressure();
        drain_results();
        write_reg(REG_INTERVAL, 32'd0);
        send_item(rand_item(ACT_CLEAR));
        calm      = 1'b1;
        sink_hold = 300;
        repeat (24) send_item(rand_item(ACT_SAMPLE));
        calm = 1'b0;
    endtask

    // random traffic under a series of register settings
    task automatic test_random_traffic();
        int                  counted;
        int unsigned         r;
        logic [ACTION_W-1:0] act;
        logic [CFG_W-1:0]    iv;
        logic [CFG_W-1:0]    me;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            case (p)
                0:       begin iv = 32'd37;         me = 32'd255; end
                1:       begin iv = 32'd1;          me = 32'd3;   end
                2:       begin iv = 32'd0;          me = 32'd1;   end
                3:       begin iv = 32'hFFFFFFFF;   me = 32'd255; end
                4:       begin iv = $urandom_range(2, 500); me = $urandom_range(1, 20); end
                5:       begin iv = INTERVAL_RST;   me = 32'(MAX_ENTRIES_RST); end
                6:       begin iv = $urandom;       me = $urandom_range(0, 255); end
                default: begin iv = 32'd5;          me = 32'd0;   end
            endcase
            write_reg(REG_INTERVAL, iv);
            write_reg(REG_MAX_ENTRIES, me);
            calm    = (p == 2 || p == 5);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    act = ACT_CLEAR;
                else if (r < 12)
                    act = ACT_FLUSH;
                else if (r < 14)
                    act = ACT_UNUSED;
                else
                    act = ACT_SAMPLE;
                tick_time();
                send_item(rand_item(act));
                if (act != ACT_UNUSED)
                    counted++;
            end
        end
        calm = 1'b0;
    endtask

    // receiver: random stalls, plus a long hold when a test asks for one
    initial
    begin
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                results_if.ready <= 1'b0;
                sink_hold--;
            end
            else if (sink_wait > 0)
            begin
                results_if.ready <= 1'b0;
                sink_wait--;
            end
            else
            begin
                results_if.ready <= 1'b1;
                sink_wait = calm ? 0 : pick_gap();
            end
        end
    end

    // check each window taken, then predict from each item taken
    always @(posedge clk)
    begin
        window_t      got;
        window_t      want;
        reading_set_t seen;
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
            begin
                got.window_time  = results_if.window_time;
                got.avg[0]       = results_if.avg_probe_temp;
                got.avg[1]       = results_if.avg_air_temp;
                got.avg[2]       = results_if.avg_aux_temp;
                got.avg[3]       = results_if.avg_humidity;
                got.avg[4]       = results_if.avg_light;
                got.avg[5]       = results_if.avg_co2;
                got.avg[6]       = results_if.avg_voc;
                got.avg[7]       = results_if.avg_aqi;
                got.avg[8]       = results_if.avg_pressure;
                got.sample_count = results_if.sample_count;
                got.dropped      = results_if.dropped;
                n_windows++;
                if (pending_windows.size() == 0)
                begin
                    log_mismatch($sformatf("window %0d arrived with none expected", n_windows));
                end
                else
                begin
                    want = pending_windows.pop_front();
                    if (want.dropped)
                        n_dropped++;
                    if (got.window_time !== want.window_time)
                        log_mismatch($sformatf("window %0d window_time: got %0h expected %0h",
                                               n_windows, got.window_time, want.window_time));
                    for (int i = 0; i < NUM_CHANNELS; i++)
                        if (got.avg[i] !== want.avg[i])
                            log_mismatch($sformatf("window %0d avg_%s: got %0d expected %0d",
                                                   n_windows, lane_name[i],
                                                   $signed(got.avg[i]), $signed(want.avg[i])));
                    if (got.sample_count !== want.sample_count)
                        log_mismatch($sformatf("window %0d sample_count: got %0d expected %0d",
                                               n_windows, got.sample_count, want.sample_count));
                    if (got.dropped !== want.dropped)
                        log_mismatch($sformatf("window %0d dropped: got %0b expected %0b",
                                               n_windows, got.dropped, want.dropped));
                end
            end
            if (samples_if.valid && samples_if.ready)
            begin
                seen.action     = samples_if.action;
                seen.reading[0] = samples_if.probe_temp;
                seen.reading[1] = samples_if.air_temp;
                seen.reading[2] = samples_if.aux_temp;
                seen.reading[3] = samples_if.humidity;
                seen.reading[4] = samples_if.light;
                seen.reading[5] = samples_if.co2;
                seen.reading[6] = samples_if.voc;
                seen.reading[7] = samples_if.aqi;
                seen.reading[8] = samples_if.pressure;
                seen.unix_time  = samples_if.unix_time;
                seen.now_ms     = samples_if.now_ms;
                act_seen[seen.action]++;
                absorb_item(seen);
            end
        end
    end

    // end a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d windows outstanding",
                 cycle_count, pending_windows.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // test sequence
    initial
    begin
        samples_if.valid      <= 1'b0;
        samples_if.action     <= ACT_SAMPLE;
        samples_if.probe_temp <= '0;
        samples_if.air_temp   <= '0;
        samples_if.aux_temp   <= '0;
        samples_if.humidity   <= '0;
        samples_if.light      <= '0;
        samples_if.co2        <= '0;
        samples_if.voc        <= '0;
        samples_if.aqi        <= '0;
        samples_if.pressure   <= '0;
        samples_if.unix_time  <= '0;
        samples_if.now_ms     <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_INTERVAL;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_rounding_extremes();
        test_window_timing();
        test_store_limit();
        test_long_window();
        test_backpressure();
        test_random_traffic();
        drain_results();

        $display("covered %0d samples, %0d flushes, %0d store clears, %0d ignored items",
                 act_seen[ACT_SAMPLE], act_seen[ACT_FLUSH], act_seen[ACT_CLEAR],
                 act_seen[ACT_UNUSED]);
        $display("checked %0d windows (%0d dropped) in %0d cycles, %0d mismatches",
                 n_windows, n_dropped, cycle_count, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
